[src/rhc_pkg.sv]
`default_nettype none
package rhc_pkg;

	localparam int SLOTS = 64;
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = 48;
	localparam int RCW = 16;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_RELEASED = 3'd2,
		ST_NOT_HELD = 3'd3,
		ST_FULL     = 3'd4
	} rhc_status_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_HIT   = 3'd1,
		OP_INS   = 3'd2,
		OP_REL   = 3'd3,
		OP_EVICT = 3'd4
	} rhc_op_t;

	typedef struct packed {
		rhc_op_t         op;
		logic [IW-1:0]   target;
		logic [KW-1:0]   key;
		logic            unlink;
		logic [IW-1:0]   rank;
		logic [IW-1:0]   new_rank;
	} rhc_cmd_t;

	typedef struct packed {
		logic matched;
		logic vacant;
		logic head;
	} rhc_chain_t;

endpackage
`default_nettype wire

[src/rhc_if.sv]
`default_nettype none
interface rhc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] host_address;
	logic [15:0] host_port;
	modport source(output valid, req_type, host_address, host_port, input ready);
	modport sink(input valid, req_type, host_address, host_port, output ready);
endinterface

interface rhc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot_index;
	logic [15:0] ref_count;
	logic        evicted;
	logic [5:0]  evicted_slot;
	modport source(output valid, status, slot_index, ref_count, evicted, evicted_slot,
		input ready);
	modport sink(input valid, status, slot_index, ref_count, evicted, evicted_slot,
		output ready);
endinterface
`default_nettype wire

[src/rhc_cell.sv]
`default_nettype none
module rhc_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [rhc_pkg::IW-1:0]    my_idx,
	input  wire rhc_pkg::rhc_cmd_t         cmd,
	input  wire rhc_pkg::rhc_chain_t       chain_in,
	output rhc_pkg::rhc_chain_t            chain_out,
	output rhc_pkg::rhc_chain_t            sel,
	output logic [rhc_pkg::RCW-1:0]        refs,
	output logic [rhc_pkg::IW-1:0]         rank
);

	logic                      valid_q;
	logic [rhc_pkg::KW-1:0]    key_q;
	logic [rhc_pkg::RCW-1:0]   refs_q;
	logic [rhc_pkg::IW-1:0]    rank_q;
	rhc_pkg::rhc_chain_t       mine;
	logic                      me;
	logic                      is_free;

	assign is_free = valid_q && (refs_q == '0);
	assign me = (cmd.target == my_idx);
	assign mine.matched = valid_q && (key_q == cmd.key);
	assign mine.vacant = !valid_q;
	assign mine.head = is_free && (rank_q == '0);
	assign chain_out = chain_in | mine;
	assign sel = mine & ~chain_in;
	assign refs = refs_q;
	assign rank = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				rhc_pkg::OP_HIT: begin
					if (me && refs_q != {rhc_pkg::RCW{1'b1}}) refs_q <= refs_q + 1'b1;
				end
				rhc_pkg::OP_INS: begin
					if (me) begin
						valid_q <= 1'b1;
						key_q <= cmd.key;
						refs_q <= {{(rhc_pkg::RCW-1){1'b0}}, 1'b1};
					end
				end
				rhc_pkg::OP_REL: begin
					if (me) begin
						refs_q <= refs_q - 1'b1;
						if (refs_q == {{(rhc_pkg::RCW-1){1'b0}}, 1'b1}) rank_q <= cmd.new_rank;
					end
				end
				rhc_pkg::OP_EVICT: begin
					if (me) begin
						valid_q <= 1'b0;
						refs_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (cmd.unlink && !me && is_free && rank_q > cmd.rank) rank_q <= rank_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[src/refcounted_host_cache.sv]
// Channel  Direction  Word
// req      in         req_type, host_address, host_port
// res      out        status, slot_index, ref_count, evicted, evicted_slot
// cfg      in         max_entries write (cfg_we, cfg_wdata)
//
// Each request passes through accept, lookup and update, then eviction.
// The lookup and the update each visit the row of slot cells once, across
// the whole row.
// Reset clears all slots at once; no clearing pass is needed.
// A result waiting on res holds the eviction step until it is taken.
`default_nettype none
module refcounted_host_cache (
	input  wire logic clk,
	input  wire logic arst_n,
	rhc_req_if.sink   req,
	rhc_res_if.source res,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);

	typedef enum logic [1:0] {S_IDLE, S_ACT, S_EVC} state_t;

	state_t                         state_q;
	logic [6:0]                     max_q;
	logic                           in_req_q;
	logic [rhc_pkg::KW-1:0]         in_key_q;
	logic [rhc_pkg::CW-1:0]         used_q;
	logic [rhc_pkg::CW-1:0]         free_cnt_q;
	rhc_pkg::rhc_status_t           st_q;
	logic [rhc_pkg::IW-1:0]         slot_q;
	logic [rhc_pkg::RCW-1:0]        rc_q;
	logic                           out_valid_q;
	rhc_pkg::rhc_status_t           o_status_q;
	logic [rhc_pkg::IW-1:0]         o_slot_q;
	logic [rhc_pkg::RCW-1:0]        o_rc_q;
	logic                           o_ev_q;
	logic [rhc_pkg::IW-1:0]         o_evslot_q;

	rhc_pkg::rhc_cmd_t              cmd;
	rhc_pkg::rhc_chain_t            chain [rhc_pkg::SLOTS+1];
	rhc_pkg::rhc_chain_t            sel [rhc_pkg::SLOTS];
	logic [rhc_pkg::RCW-1:0]        c_refs [rhc_pkg::SLOTS];
	logic [rhc_pkg::IW-1:0]         c_rank [rhc_pkg::SLOTS];

	logic [rhc_pkg::IW-1:0]         m_idx, v_idx, h_idx;
	logic [rhc_pkg::RCW-1:0]        m_refs;
	logic [rhc_pkg::IW-1:0]         m_rank;
	logic                           out_free;
	logic                           do_evict;

	assign chain[0] = '0;

	for (genvar i = 0; i < rhc_pkg::SLOTS; i++) begin : g_cell
		rhc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (rhc_pkg::IW'(i)),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.sel       (sel[i]),
			.refs      (c_refs[i]),
			.rank      (c_rank[i])
		);
	end

	always_comb begin
		m_idx = '0;
		v_idx = '0;
		h_idx = '0;
		m_refs = '0;
		m_rank = '0;
		for (int i = 0; i < rhc_pkg::SLOTS; i++) begin
			if (sel[i].matched) begin
				m_idx = m_idx | i[rhc_pkg::IW-1:0];
				m_refs = m_refs | c_refs[i];
				m_rank = m_rank | c_rank[i];
			end
			if (sel[i].vacant) v_idx = v_idx | i[rhc_pkg::IW-1:0];
			if (sel[i].head) h_idx = h_idx | i[rhc_pkg::IW-1:0];
		end
	end

	assign out_free = !out_valid_q || res.ready;
	assign do_evict = (used_q > max_q) && chain[rhc_pkg::SLOTS].head;

	always_comb begin
		cmd = '0;
		cmd.op = rhc_pkg::OP_NONE;
		cmd.key = in_key_q;
		cmd.new_rank = free_cnt_q[rhc_pkg::IW-1:0];
		if (state_q == S_ACT) begin
			if (!in_req_q) begin
				if (chain[rhc_pkg::SLOTS].matched) begin
					cmd.op = rhc_pkg::OP_HIT;
					cmd.target = m_idx;
					cmd.unlink = (m_refs == '0);
					cmd.rank = m_rank;
				end else if (chain[rhc_pkg::SLOTS].vacant) begin
					cmd.op = rhc_pkg::OP_INS;
					cmd.target = v_idx;
				end
			end else if (chain[rhc_pkg::SLOTS].matched && m_refs != '0) begin
				cmd.op = rhc_pkg::OP_REL;
				cmd.target = m_idx;
			end
		end else if (state_q == S_EVC && out_free && do_evict) begin
			cmd.op = rhc_pkg::OP_EVICT;
			cmd.target = h_idx;
			cmd.unlink = 1'b1;
			cmd.rank = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= 7'd64;
			used_q <= '0;
			free_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) max_q <= cfg_wdata;
			if (out_valid_q && res.ready && state_q != S_EVC) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						in_req_q <= req.req_type;
						in_key_q <= {req.host_address, req.host_port};
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (!in_req_q && chain[rhc_pkg::SLOTS].matched) begin
						st_q <= rhc_pkg::ST_HIT;
						slot_q <= m_idx;
						rc_q <= (m_refs == {rhc_pkg::RCW{1'b1}}) ? m_refs : m_refs + 1'b1;
						if (m_refs == '0) free_cnt_q <= free_cnt_q - 1'b1;
					end else if (!in_req_q && chain[rhc_pkg::SLOTS].vacant) begin
						st_q <= rhc_pkg::ST_INSERTED;
						slot_q <= v_idx;
						rc_q <= {{(rhc_pkg::RCW-1){1'b0}}, 1'b1};
						used_q <= used_q + 1'b1;
					end else if (!in_req_q) begin
						st_q <= rhc_pkg::ST_FULL;
						slot_q <= '0;
						rc_q <= '0;
					end else if (chain[rhc_pkg::SLOTS].matched && m_refs != '0) begin
						st_q <= rhc_pkg::ST_RELEASED;
						slot_q <= m_idx;
						rc_q <= m_refs - 1'b1;
						if (m_refs == {{(rhc_pkg::RCW-1){1'b0}}, 1'b1})
							free_cnt_q <= free_cnt_q + 1'b1;
					end else begin
						st_q <= rhc_pkg::ST_NOT_HELD;
						slot_q <= chain[rhc_pkg::SLOTS].matched ? m_idx : '0;
						rc_q <= '0;
					end
					state_q <= S_EVC;
				end
				S_EVC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						o_status_q <= st_q;
						o_slot_q <= slot_q;
						o_rc_q <= (do_evict && h_idx == slot_q) ? '0 : rc_q;
						o_ev_q <= do_evict;
						o_evslot_q <= do_evict ? h_idx : '0;
						if (do_evict) begin
							used_q <= used_q - 1'b1;
							free_cnt_q <= free_cnt_q - 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign res.valid = out_valid_q;
	assign res.status = o_status_q;
	assign res.slot_index = o_slot_q;
	assign res.ref_count = o_rc_q;
	assign res.evicted = o_ev_q;
	assign res.evicted_slot = o_evslot_q;

endmodule
`default_nettype wire

[src/rhc_checker.sv]
`default_nettype none
module rhc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  status,
	input wire logic [15:0] ref_count,
	input wire logic        evicted,
	input wire logic [5:0]  evicted_slot
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= 3'd4)
		else $error("bad status");

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == 3'd0 || status == 3'd1) |-> ref_count != 16'd0)
		else $error("held entry reports zero count");

	a_evslot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !evicted |-> evicted_slot == 6'd0)
		else $error("evicted slot without eviction");

endmodule

bind refcounted_host_cache rhc_checker u_rhc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.status       (res.status),
	.ref_count    (res.ref_count),
	.evicted      (res.evicted),
	.evicted_slot (res.evicted_slot)
);
`default_nettype wire
